>>> rtl/ffp_pkg.sv
// Shared types and constants of the first-fit two-resource packer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ffp_pkg;

  localparam int unsigned CPU_W        = 7;
  localparam int unsigned MEM_W        = 18;
  localparam int unsigned IDX_OUT_W    = 8;
  localparam int unsigned CNT_OUT_W    = 9;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 18;

  localparam int unsigned MAX_SERVERS_DEF = 256;

  localparam logic [CPU_W-1:0] CPU_CAP_RST = CPU_W'(56);
  localparam logic [MEM_W-1:0] MEM_CAP_RST = MEM_W'(1024 * 128);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_CPU_CAP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_CAP = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_FULL    = 2'd1,
    ST_TOO_BIG = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic [CPU_W-1:0] req_cpu;
    logic [MEM_W-1:0] req_mem_mb;
  } req_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] server_index;
    logic                 opened_new;
    status_e              status;
    logic [CNT_OUT_W-1:0] servers_in_use;
  } res_t;

  // Remaining amounts of one server
  typedef struct packed {
    logic [CPU_W-1:0] cpu;
    logic [MEM_W-1:0] mem;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/first_fit_two_resource_packer.sv
// Top level of the first-fit two-resource packer: control, scan and result register.
// Depends on ffp_pkg and ffp_server_ram.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Request channel: drive req_i and raise start_i; the item is taken at a
//   rising edge where start_i is high and busy_o is low. One item is worked
//   on at a time; busy_o stays high while the server table is scanned.
//   Result channel: done_o is high for exactly one cycle with res_o holding
//   the server index, the new-server flag, the status and the count of open
//   servers. The receiver cannot stall; it must take the item in that cycle.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 CPU capacity, 1 memory capacity) at the edge; other indexes are
//   dropped. Write only while no item is in flight.
// Scan
//   An oversized request, or one that opens the first server, needs no
//   scan. Otherwise the scan reads one server entry per cycle from the
//   single read port of the server memory, from server 0 upward, until an
//   entry fits or the last open one is read; then a new server is opened or
//   the table is reported full. The next item may start in the cycle an
//   item's result is shown.
// Reset
//   Clears the open-server count and loads the default capacities (56 cores,
//   131072 MB). Server entries need no clearing: only opened ones are read.
module first_fit_two_resource_packer #(
  parameter int unsigned MAX_SERVERS = ffp_pkg::MAX_SERVERS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output      logic                               busy_o,
  input  wire ffp_pkg::req_t                      req_i,
  output      logic                               done_o,
  output      ffp_pkg::res_t                      res_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [ffp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [ffp_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ffp_pkg::*;

  localparam int unsigned IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SERVERS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SERVERS);

  state_e           state_q, state_d;
  logic [CPU_W-1:0] cpu_cap_q;
  logic [MEM_W-1:0] mem_cap_q;
  req_t             req_q, req_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] scan_idx_q, scan_idx_d;
  logic             done_q, done_d;
  res_t             res_q, res_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  logic             accept;
  logic             too_big;
  logic             fits;
  logic             last_entry;
  logic [CNT_W-1:0] last_idx;

  assign accept   = start_i && (state_q == S_IDLE);
  assign too_big  = (req_i.req_cpu > cpu_cap_q) || (req_i.req_mem_mb > mem_cap_q);
  assign fits     = (ram_rdata.cpu >= req_q.req_cpu) && (ram_rdata.mem >= req_q.req_mem_mb);
  assign last_idx = CNT_W'(count_q - 1'b1);
  assign last_entry = (CNT_W'(scan_idx_q) == last_idx);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !too_big && (count_q != '0)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (fits || last_entry) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    req_d      = req_q;
    count_d    = count_q;
    scan_idx_d = scan_idx_q;
    done_d     = 1'b0;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_waddr  = IDX_W'(count_q);
    ram_wdata  = '{cpu: cpu_cap_q - req_q.req_cpu, mem: mem_cap_q - req_q.req_mem_mb};
    ram_re     = 1'b0;
    ram_raddr  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = req_i;
          if (too_big) begin
            done_d = 1'b1;
            res_d  = '{server_index: '0, opened_new: 1'b0, status: ST_TOO_BIG,
                       servers_in_use: CNT_OUT_W'(count_q)};
          end else if (count_q == '0) begin
            // Empty table: open server 0 at once
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = '{cpu: cpu_cap_q - req_i.req_cpu,
                          mem: mem_cap_q - req_i.req_mem_mb};
            count_d   = CNT_W'(1);
            done_d    = 1'b1;
            res_d     = '{server_index: '0, opened_new: 1'b1, status: ST_PLACED,
                          servers_in_use: CNT_OUT_W'(1)};
          end else begin
            // Fetch server 0; its data arrives in the first scan cycle
            ram_re     = 1'b1;
            ram_raddr  = '0;
            scan_idx_d = '0;
          end
        end
      end
      S_SCAN: begin
        if (fits) begin
          // Reduce the hit entry in place
          ram_we    = 1'b1;
          ram_waddr = scan_idx_q;
          ram_wdata = '{cpu: ram_rdata.cpu - req_q.req_cpu,
                        mem: ram_rdata.mem - req_q.req_mem_mb};
          done_d    = 1'b1;
          res_d     = '{server_index: IDX_OUT_W'(scan_idx_q), opened_new: 1'b0,
                        status: ST_PLACED, servers_in_use: CNT_OUT_W'(count_q)};
        end else if (last_entry) begin
          done_d = 1'b1;
          if (count_q == CNT_MAX) begin
            res_d = '{server_index: '0, opened_new: 1'b0, status: ST_FULL,
                      servers_in_use: CNT_OUT_W'(count_q)};
          end else begin
            // Open the next server with the configured capacity
            ram_we  = 1'b1;
            count_d = CNT_W'(count_q + 1'b1);
            res_d   = '{server_index: IDX_OUT_W'(count_q), opened_new: 1'b1,
                        status: ST_PLACED, servers_in_use: CNT_OUT_W'(count_q + 1'b1)};
          end
        end else begin
          // Advance: fetch the next entry while this one is dropped
          ram_re     = 1'b1;
          ram_raddr  = IDX_W'(scan_idx_q + 1'b1);
          scan_idx_d = IDX_W'(scan_idx_q + 1'b1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      done_q    <= 1'b0;
      cpu_cap_q <= CPU_CAP_RST;
      mem_cap_q <= MEM_CAP_RST;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        priority case (cfg_idx_i)
          CFG_CPU_CAP: cpu_cap_q <= cfg_data_i[CPU_W-1:0];
          CFG_MEM_CAP: mem_cap_q <= cfg_data_i[MEM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    scan_idx_q <= scan_idx_d;
    res_q      <= res_d;
  end

  ffp_server_ram #(
    .DEPTH  (MAX_SERVERS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

>>> rtl/ffp_server_ram.sv
// Per-server remaining CPU and memory: one write and one read port, registered read.
// Depends on ffp_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module ffp_server_ram #(
  parameter int unsigned DEPTH  = ffp_pkg::MAX_SERVERS_DEF,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [ADDR_W-1:0]   waddr_i,
  input  wire ffp_pkg::entry_t     wdata_i,
  input  wire logic                re_i,
  input  wire logic [ADDR_W-1:0]   raddr_i,
  output      ffp_pkg::entry_t     rdata_o
);
  import ffp_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench of first_fit_two_resource_packer: directed and random placement items.
// Depends on ffp_pkg and the packer RTL; a scoreboard class predicts every result.
`timescale 1ns / 1ps

module testbench;
  import ffp_pkg::*;

  localparam int unsigned SERVER_SLOTS = MAX_SERVERS_DEF;
  localparam int unsigned CPU_MAX      = (1 << CPU_W) - 1;
  localparam int unsigned MEM_MAX      = (1 << MEM_W) - 1;

  // Indexes past the two capacity registers; the block must drop writes to them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  // Mirror of the server table plus the queue of placements still owed by the block.
  class placement_scoreboard;
    logic [CPU_W-1:0] cpu_left [SERVER_SLOTS];
    logic [MEM_W-1:0] mem_left [SERVER_SLOTS];
    int unsigned      open_servers;
    logic [CPU_W-1:0] cpu_cap;
    logic [MEM_W-1:0] mem_cap;
    res_t             owed_placements [$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      opened;
    int unsigned      full_hits;
    int unsigned      oversized_hits;

    function new();
      cpu_cap        = CPU_CAP_RST;
      mem_cap        = MEM_CAP_RST;
      open_servers   = 0;
      mismatches     = 0;
      checked        = 0;
      opened         = 0;
      full_hits      = 0;
      oversized_hits = 0;
    endfunction

    function int unsigned pending();
      return owed_placements.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_CPU_CAP) begin
        cpu_cap = data[CPU_W-1:0];
      end else if (idx == CFG_MEM_CAP) begin
        mem_cap = data[MEM_W-1:0];
      end
    endfunction

    // First fit: lowest-numbered open server with room for both amounts wins.
    function void note_request(req_t r);
      res_t        e;
      int unsigned k;
      bit          found;
      e     = '0;
      found = 1'b0;
      if (r.req_cpu > cpu_cap || r.req_mem_mb > mem_cap) begin
        e.status = ST_TOO_BIG;
        oversized_hits++;
      end else begin
        for (k = 0; k < open_servers && !found; k++) begin
          if (cpu_left[k] >= r.req_cpu && mem_left[k] >= r.req_mem_mb) begin
            found          = 1'b1;
            cpu_left[k]    = cpu_left[k] - r.req_cpu;
            mem_left[k]    = mem_left[k] - r.req_mem_mb;
            e.server_index = k[IDX_OUT_W-1:0];
            e.status       = ST_PLACED;
          end
        end
        if (!found) begin
          if (open_servers >= SERVER_SLOTS) begin
            e.status = ST_FULL;
            full_hits++;
          end else begin
            cpu_left[open_servers] = cpu_cap - r.req_cpu;
            mem_left[open_servers] = mem_cap - r.req_mem_mb;
            e.server_index         = open_servers[IDX_OUT_W-1:0];
            e.opened_new           = 1'b1;
            e.status               = ST_PLACED;
            open_servers++;
            opened++;
          end
        end
      end
      e.servers_in_use = open_servers[CNT_OUT_W-1:0];
      owed_placements.push_back(e);
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (owed_placements.size() == 0) begin
        $error("result with no item waiting: server_index %0d status %0d",
               got.server_index, got.status);
        mismatches++;
        return;
      end
      e = owed_placements.pop_front();
      checked++;
      if (got.server_index !== e.server_index) begin
        $error("server_index: expected %0d, got %0d", e.server_index, got.server_index);
        mismatches++;
      end
      if (got.opened_new !== e.opened_new) begin
        $error("opened_new: expected %0d, got %0d", e.opened_new, got.opened_new);
        mismatches++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        mismatches++;
      end
      if (got.servers_in_use !== e.servers_in_use) begin
        $error("servers_in_use: expected %0d, got %0d", e.servers_in_use, got.servers_in_use);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  req_t                  req_i;
  logic                  done_o;
  res_t                  res_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  placement_scoreboard sb;

  // Capacities the stimulus currently sizes its items against
  int unsigned cur_cpu_cap;
  int unsigned cur_mem_cap;

  first_fit_two_resource_packer #(
    .MAX_SERVERS(SERVER_SLOTS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .req_i     (req_i),
    .done_o    (done_o),
    .res_o     (res_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Sample everything at the rising edge: register writes, accepted items and
  // result strobes all see the values that were stable before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        sb.write_reg(cfg_idx_i, cfg_data_i);
      end
      if (start_i && !busy_o) begin
        sb.note_request(req_i);
      end
      if (done_o === 1'b1) begin
        sb.check_result(res_o);
      end
    end
  end

  // Present one item at the falling edge and hold it until the block takes it.
  // Leave start high on return so a burst can follow without a bubble.
  task automatic drive_request(input req_t r);
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic place(input int unsigned cpu, input int unsigned mem);
    req_t r;
    r.req_cpu    = cpu[CPU_W-1:0];
    r.req_mem_mb = mem[MEM_W-1:0];
    drive_request(r);
  endtask

  // Drop start and let the given number of cycles go by.
  task automatic pause_requests(input int unsigned cycles);
    @(negedge clk_i);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drop start and hold until every owed placement has come back.
  task automatic wait_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // The CPU register is narrower than the data bus: fill the unused upper
  // bits with noise so that the block is seen to ignore them.
  task automatic set_capacity(input int unsigned cpu_cap, input int unsigned mem_cap);
    logic [CFG_DATA_W-1:0] cpu_word;
    cpu_word = {CFG_DATA_W'($urandom_range(2047, 0)) << CPU_W};
    cpu_word[CPU_W-1:0] = cpu_cap[CPU_W-1:0];
    wait_idle();
    write_reg(CFG_CPU_CAP, cpu_word);
    write_reg(CFG_MEM_CAP, mem_cap[CFG_DATA_W-1:0]);
    cur_cpu_cap = cpu_cap;
    cur_mem_cap = mem_cap;
  endtask

  // Mostly items that fit, spread over size classes so that servers fill
  // unevenly; the rest are oversized, zero, exactly full-size or pure noise.
  function automatic req_t make_request(input int unsigned cpu_cap, input int unsigned mem_cap);
    req_t        r;
    int unsigned kind;
    int unsigned div;
    kind         = $urandom_range(99, 0);
    r.req_cpu    = CPU_W'($urandom_range(CPU_MAX, 0));
    r.req_mem_mb = MEM_W'($urandom_range(MEM_MAX, 0));
    if (kind < 6) begin
      // keep the noise item
    end else if (kind < 14 && (cpu_cap < CPU_MAX || mem_cap < MEM_MAX)) begin
      if (cpu_cap < CPU_MAX && (mem_cap == MEM_MAX || $urandom_range(1, 0) == 1)) begin
        r.req_cpu    = CPU_W'($urandom_range(CPU_MAX, cpu_cap + 1));
        r.req_mem_mb = MEM_W'($urandom_range(mem_cap, 0));
      end else begin
        r.req_cpu    = CPU_W'($urandom_range(cpu_cap, 0));
        r.req_mem_mb = MEM_W'($urandom_range(MEM_MAX, mem_cap + 1));
      end
    end else if (kind < 18) begin
      if ($urandom_range(1, 0) == 1) begin
        r = '0;
      end else begin
        r.req_cpu    = cpu_cap[CPU_W-1:0];
        r.req_mem_mb = mem_cap[MEM_W-1:0];
      end
    end else begin
      div          = 32'(1) << $urandom_range(3, 0);
      r.req_cpu    = CPU_W'($urandom_range(cpu_cap / div, 0));
      r.req_mem_mb = MEM_W'($urandom_range(mem_cap / div, 0));
    end
    return r;
  endfunction

  // Send items in bursts of random length; long bursts give stretches
  // with no idling, short gaps land on every cycle of a scan.
  task automatic run_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < n_items) begin
      burst = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 16) : $urandom_range(8, 1);
      repeat (burst) begin
        if (sent < n_items) begin
          drive_request(make_request(cur_cpu_cap, cur_mem_cap));
          sent++;
        end
      end
      if ($urandom_range(4, 0) != 0) begin
        pause_requests($urandom_range(30, 1));
      end
    end
  endtask

  initial begin
    sb          = new();
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    cur_cpu_cap = 32'(CPU_CAP_RST);
    cur_mem_cap = 32'(MEM_CAP_RST);
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset capacities, first server opened by a zero item, an item
    // that takes a whole server, oversized in each resource, exact fits.
    place(0, 0);
    place(56, 131072);
    place(0, 0);
    place(57, 1);
    place(CPU_MAX, MEM_MAX);
    place(1, 131073);
    place(1, 1);
    place(55, 131071);
    place(1, 0);
    place(0, 1);
    place(20, 1000);
    place(40, 5);
    place(30, 100);

    // Raise both capacities to the top: old servers must keep what they had left
    set_capacity(CPU_MAX, MEM_MAX);
    place(CPU_MAX, MEM_MAX);
    place(100, 200000);
    place(27, 62143);
    place(0, 0);

    // Drop to the smallest capacities and poke the unused register indexes
    set_capacity(1, 1);
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, CFG_DATA_W'(18'h15555));
    place(1, 1);
    place(2, 1);
    place(1, 2);
    place(0, 0);

    // Random phases; the small-capacity phase drives the table to full
    set_capacity(56, 131072);
    run_phase(300);
    set_capacity(CPU_MAX, MEM_MAX);
    run_phase(300);
    set_capacity($urandom_range(CPU_MAX, 8), $urandom_range(MEM_MAX, 1024));
    run_phase(250);
    set_capacity(0, $urandom_range(MEM_MAX, 1));
    write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom_range(MEM_MAX, 0)));
    run_phase(60);
    set_capacity(1, 1);
    run_phase(240);
    set_capacity($urandom_range(CPU_MAX, 1), $urandom_range(MEM_MAX, 1));
    write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom_range(MEM_MAX, 0)));
    run_phase(300);

    // Drain, then keep watching for stray strobes over a full scan or two
    wait_idle();
    repeat (2 * SERVER_SLOTS) @(negedge clk_i);

    $display("summary: %0d results checked, %0d servers opened, %0d table-full, %0d oversized",
             sb.checked, sb.opened, sb.full_hits, sb.oversized_hits);
    $display("summary: %0d field mismatches, %0d results still owed",
             sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Guard against a hung handshake; several times the slowest legal run
  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/ffp_pkg.sv
rtl/ffp_server_ram.sv
rtl/first_fit_two_resource_packer.sv
test/testbench.sv
